// File: rtl/sdh_pkg.sv
package sdh_pkg;

    // Default sizes
    localparam int SDH_CARD_BYTES      = 524288;
    localparam int SDH_MAX_BLOCK_BYTES = 4096;

    // Item commands
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_INSERT = 2'd2;
    localparam logic [1:0] CMD_EJECT  = 2'd3;

    localparam logic [31:0] HOST_BASE = 32'h400b_1000;
    localparam logic [31:0] RCA_VALUE = 32'h0001_0000;

    // Register word indexes
    localparam logic [5:0] W_DSADDR   = 6'd0;
    localparam logic [5:0] W_BLKATTR  = 6'd1;
    localparam logic [5:0] W_CMDARG   = 6'd2;
    localparam logic [5:0] W_XFERTYP  = 6'd3;
    localparam logic [5:0] W_RSP0     = 6'd4;
    localparam logic [5:0] W_RSP1     = 6'd5;
    localparam logic [5:0] W_RSP2     = 6'd6;
    localparam logic [5:0] W_RSP3     = 6'd7;
    localparam logic [5:0] W_DATPORT  = 6'd8;
    localparam logic [5:0] W_PRSSTAT  = 6'd9;
    localparam logic [5:0] W_PROCTL   = 6'd10;
    localparam logic [5:0] W_SYSCTL   = 6'd11;
    localparam logic [5:0] W_IRQSTAT  = 6'd12;
    localparam logic [5:0] W_IRQSTATEN = 6'd13;
    localparam logic [5:0] W_IRQSIGEN = 6'd14;
    localparam logic [5:0] W_AC12ERR  = 6'd15;
    localparam logic [5:0] W_HTCAPBLT = 6'd16;
    localparam logic [5:0] W_WML      = 6'd17;
    localparam logic [5:0] W_FEVT     = 6'd20;
    localparam logic [5:0] W_ADMAES   = 6'd21;
    localparam logic [5:0] W_ADSADDR  = 6'd22;
    localparam logic [5:0] W_VENDOR   = 6'd48;
    localparam logic [5:0] W_MMCBOOT  = 6'd49;
    localparam logic [5:0] W_HOSTVER  = 6'd63;

    localparam logic [31:0] CAP_VALUE  = 32'h07f3_0000;
    localparam logic [31:0] WML_VALUE  = 32'h0080_0080;
    localparam logic [31:0] VER_VALUE  = 32'h0000_1201;
    localparam logic [31:0] SRST_MASK  = 32'h0700_0000;
    localparam logic [31:0] SYSCTL_KEEP = 32'h000f_ffff;

    // Interrupt status bits
    localparam logic [31:0] IRQ_CC   = 32'h0000_0001;
    localparam logic [31:0] IRQ_TC   = 32'h0000_0002;
    localparam logic [31:0] IRQ_BWR  = 32'h0000_0010;
    localparam logic [31:0] IRQ_BRR  = 32'h0000_0020;
    localparam logic [31:0] IRQ_CINS = 32'h0000_0040;
    localparam logic [31:0] IRQ_CRM  = 32'h0000_0080;
    localparam logic [31:0] IRQ_CTO  = 32'h0001_0000;
    localparam logic [31:0] IRQ_DTO  = 32'h0010_0000;
    localparam logic [31:0] IRQ_DCRC = 32'h0020_0000;

    // SD command indexes
    localparam logic [5:0] SD_CMD0  = 6'd0;
    localparam logic [5:0] SD_CMD2  = 6'd2;
    localparam logic [5:0] SD_CMD3  = 6'd3;
    localparam logic [5:0] SD_CMD7  = 6'd7;
    localparam logic [5:0] SD_CMD8  = 6'd8;
    localparam logic [5:0] SD_CMD9  = 6'd9;
    localparam logic [5:0] SD_CMD12 = 6'd12;
    localparam logic [5:0] SD_CMD13 = 6'd13;
    localparam logic [5:0] SD_CMD16 = 6'd16;
    localparam logic [5:0] SD_CMD17 = 6'd17;
    localparam logic [5:0] SD_CMD18 = 6'd18;
    localparam logic [5:0] SD_CMD24 = 6'd24;
    localparam logic [5:0] SD_CMD25 = 6'd25;
    localparam logic [5:0] SD_CMD41 = 6'd41;
    localparam logic [5:0] SD_CMD55 = 6'd55;

    // Result of one step, handed from the register block to the result stage
    typedef struct packed {
        logic        acc;
        logic        port_rd;
        logic [31:0] rd;
        logic [3:0]  mask;
        logic        irq;
    } t_step_res;

endpackage

// File: rtl/sdh_store.sv
module sdh_store import sdh_pkg::*; #(
    parameter int CARD_BYTES = SDH_CARD_BYTES,
    localparam int CARD_WORDS = CARD_BYTES / 4,
    localparam int AW = $clog2(CARD_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [3:0]    i_be,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata,
    output logic          o_busy
);

    logic [3:0][7:0] mem [CARD_WORDS];
    logic            r_busy;
    logic [AW-1:0]   r_clr_addr;
    logic [31:0]     r_rdata;

    // Sweep the store with zeros after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(CARD_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Byte-lane write, clear pass first
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            for (int b = 0; b < 4; b++) begin
                if (i_be[b]) begin
                    mem[i_waddr][b] <= i_wdata[8*b +: 8];
                end
            end
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

// File: rtl/sdh_regs.sv
module sdh_regs import sdh_pkg::*; #(
    parameter int CARD_BYTES      = SDH_CARD_BYTES,
    parameter int MAX_BLOCK_BYTES = SDH_MAX_BLOCK_BYTES,
    localparam int CARD_WORDS = CARD_BYTES / 4,
    localparam int AW = $clog2(CARD_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_step,
    input  logic [1:0]    i_command,
    input  logic [31:0]   i_bus_address,
    input  logic [7:0]    i_access_size,
    input  logic [31:0]   i_write_data,
    input  logic [10:0]   i_card_blocks,
    input  logic          i_write_protect,
    output t_step_res     o_res,
    output logic          o_mem_we,
    output logic [3:0]    o_mem_be,
    output logic [AW-1:0] o_mem_waddr,
    output logic [31:0]   o_mem_wdata,
    output logic          o_mem_re,
    output logic [AW-1:0] o_mem_raddr
);

    localparam int OFS_W = $clog2(CARD_BYTES) + 1;
    localparam int MAX_CARD_BLOCKS = CARD_BYTES / 512;

    logic        r_cen;
    logic [31:0] r_dsaddr, n_dsaddr, r_blkattr, n_blkattr, r_cmdarg, n_cmdarg;
    logic [31:0] r_xfertyp, n_xfertyp, r_proctl, n_proctl, r_sysctl, n_sysctl;
    logic [31:0] r_irqstat, n_irqstat, r_irqstaten, n_irqstaten, r_irqsigen, n_irqsigen;
    logic [31:0] r_adsaddr, n_adsaddr, r_vendor, n_vendor, r_mmcboot, n_mmcboot;
    logic [31:0] r_rsp [4];
    logic [31:0] n_rsp [4];
    logic [10:0] r_size, n_size;
    logic        r_present, n_present, r_locked, n_locked, r_sel, n_sel;
    logic        r_app, n_app, r_isrd, n_isrd;
    logic [12:0] r_blklen, n_blklen;
    logic [OFS_W-1:0] r_ofs, n_ofs, r_rem, n_rem;

    logic        dec, rd_ok, wr_ok, acc, port_rd, mem_we;
    logic [31:0] off, rd, flags, prs, room, arg;
    logic [5:0]  widx, idx;
    logic [2:0]  cnt;
    logic [3:0]  mask;
    logic [12:0] bsize;
    logic [15:0] bcnt;
    logic [28:0] total;
    logic        xfer, xfer_rd, xfer_multi, bad;

    // Decode the bus access
    always_comb begin
        off  = i_bus_address - HOST_BASE;
        widx = off[7:2];
        dec  = r_cen && (i_access_size == 8'd4) && (i_bus_address >= HOST_BASE) &&
               (off <= 32'h0000_00fc) && (off[1:0] == 2'b00);
        rd_ok = (widx <= W_WML) || (widx == W_ADMAES) || (widx == W_ADSADDR) ||
                (widx == W_VENDOR) || (widx == W_MMCBOOT) || (widx == W_HOSTVER);
        wr_ok = (widx <= W_XFERTYP) || (widx == W_DATPORT) ||
                (widx >= W_PROCTL && widx <= W_IRQSIGEN) || (widx == W_FEVT) ||
                (widx == W_ADSADDR) || (widx == W_VENDOR) || (widx == W_MMCBOOT);
    end

    // Present-state word and data port byte count
    always_comb begin
        prs = 32'h0000_0008;
        if (r_present) begin
            prs = prs | 32'hff81_0000;
        end
        if (r_rem != '0) begin
            prs = prs | 32'h0000_0004 | (r_isrd ? 32'h0000_0a00 : 32'h0000_0500);
        end
        cnt = (r_rem >= OFS_W'(4)) ? 3'd4 : r_rem[2:0];
        case (cnt)
            3'd1:    mask = 4'b0001;
            3'd2:    mask = 4'b0011;
            3'd3:    mask = 4'b0111;
            3'd4:    mask = 4'b1111;
            default: mask = 4'b0000;
        endcase
        if (r_ofs >= OFS_W'(CARD_BYTES)) begin
            mask = 4'b0000;
        end
    end

    // Transfer setup check for the block commands
    always_comb begin
        idx        = i_write_data[29:24];
        arg        = r_cmdarg;
        xfer_rd    = (idx == SD_CMD17) || (idx == SD_CMD18);
        xfer_multi = (idx == SD_CMD18) || (idx == SD_CMD25);
        xfer       = xfer_rd || (idx == SD_CMD24) || (idx == SD_CMD25);
        bsize      = (r_blkattr[12:0] == '0) ? r_blklen : r_blkattr[12:0];
        bcnt       = 16'd1;
        if (xfer_multi && r_blkattr[31:16] != '0) begin
            bcnt = r_blkattr[31:16];
        end
        total = {16'd0, bsize} * {13'd0, bcnt};
        room  = ({21'd0, r_size} - arg) << 9;
        bad   = !r_sel || (bsize == '0) || ({19'd0, bsize} > 32'(MAX_BLOCK_BYTES)) ||
                (arg > {21'd0, r_size}) || ({3'd0, total} > room);
    end

    // Next state of one step
    always_comb begin
        n_dsaddr = r_dsaddr;  n_blkattr = r_blkattr;  n_cmdarg = r_cmdarg;
        n_xfertyp = r_xfertyp; n_proctl = r_proctl;   n_sysctl = r_sysctl;
        n_irqstat = r_irqstat; n_irqstaten = r_irqstaten; n_irqsigen = r_irqsigen;
        n_adsaddr = r_adsaddr; n_vendor = r_vendor;   n_mmcboot = r_mmcboot;
        n_rsp     = r_rsp;
        n_size = r_size; n_present = r_present; n_locked = r_locked; n_sel = r_sel;
        n_app = r_app; n_isrd = r_isrd; n_blklen = r_blklen; n_ofs = r_ofs; n_rem = r_rem;
        acc = 1'b0; port_rd = 1'b0; rd = '0; flags = '0; mem_we = 1'b0;

        unique case (i_command)
            CMD_READ: begin
                if (dec) begin
                    if (widx == W_DATPORT) begin
                        if (r_isrd && r_rem != '0) begin
                            acc     = 1'b1;
                            port_rd = 1'b1;
                        end
                    end else if (rd_ok) begin
                        acc = 1'b1;
                        unique case (widx)
                            W_DSADDR:   rd = r_dsaddr;
                            W_BLKATTR:  rd = r_blkattr;
                            W_CMDARG:   rd = r_cmdarg;
                            W_XFERTYP:  rd = r_xfertyp;
                            W_RSP0:     rd = r_rsp[0];
                            W_RSP1:     rd = r_rsp[1];
                            W_RSP2:     rd = r_rsp[2];
                            W_RSP3:     rd = r_rsp[3];
                            W_PRSSTAT:  rd = prs;
                            W_PROCTL:   rd = r_proctl;
                            W_SYSCTL:   rd = r_sysctl;
                            W_IRQSTAT:  rd = r_irqstat;
                            W_IRQSTATEN: rd = r_irqstaten;
                            W_IRQSIGEN: rd = r_irqsigen;
                            W_HTCAPBLT: rd = CAP_VALUE;
                            W_WML:      rd = WML_VALUE;
                            W_ADSADDR:  rd = r_adsaddr;
                            W_VENDOR:   rd = r_vendor;
                            W_MMCBOOT:  rd = r_mmcboot;
                            W_HOSTVER:  rd = VER_VALUE;
                            default:    rd = '0;
                        endcase
                    end
                end
                if (port_rd) begin
                    n_ofs = r_ofs + OFS_W'(cnt);
                    n_rem = r_rem - OFS_W'(cnt);
                    if (n_rem == '0) begin
                        flags = flags | IRQ_TC;
                    end
                end
            end
            CMD_WRITE: begin
                if (dec && wr_ok) begin
                    acc = 1'b1;
                    if (widx == W_DATPORT) begin
                        if (!r_isrd && r_rem != '0) begin
                            mem_we = 1'b1;
                            n_ofs  = r_ofs + OFS_W'(cnt);
                            n_rem  = r_rem - OFS_W'(cnt);
                            if (n_rem == '0) begin
                                flags = flags | IRQ_TC;
                            end
                        end else begin
                            acc = 1'b0;
                        end
                    end else if (widx == W_IRQSTAT) begin
                        n_irqstat = r_irqstat & ~i_write_data;
                    end else if (widx == W_FEVT) begin
                        flags = i_write_data;
                    end else if (widx == W_SYSCTL && (i_write_data & SRST_MASK) != '0) begin
                        // soft reset: registers and command state, card kept
                        n_dsaddr = '0; n_blkattr = '0; n_cmdarg = '0; n_xfertyp = '0;
                        n_proctl = '0; n_irqstat = '0; n_irqstaten = '0; n_irqsigen = '0;
                        n_adsaddr = '0; n_vendor = '0; n_mmcboot = '0;
                        n_rsp = '{default: '0};
                        n_ofs = '0; n_rem = '0; n_blklen = 13'd512;
                        n_app = 1'b0; n_sel = 1'b0; n_isrd = 1'b0;
                        n_sysctl = i_write_data & SYSCTL_KEEP;
                    end else begin
                        unique case (widx)
                            W_DSADDR:    n_dsaddr = i_write_data;
                            W_BLKATTR:   n_blkattr = i_write_data;
                            W_CMDARG:    n_cmdarg = i_write_data;
                            W_XFERTYP:   n_xfertyp = i_write_data;
                            W_PROCTL:    n_proctl = i_write_data;
                            W_SYSCTL:    n_sysctl = i_write_data;
                            W_IRQSTATEN: n_irqstaten = i_write_data;
                            W_IRQSIGEN:  n_irqsigen = i_write_data;
                            W_ADSADDR:   n_adsaddr = i_write_data;
                            W_VENDOR:    n_vendor = i_write_data;
                            W_MMCBOOT:   n_mmcboot = i_write_data;
                            default:     n_dsaddr = r_dsaddr;
                        endcase
                        // execute the command on a transfer-type write
                        if (widx == W_XFERTYP) begin
                            n_rsp = '{default: '0};
                            if (idx != SD_CMD0 && !r_present) begin
                                flags = IRQ_CTO;
                            end else begin
                                n_app = 1'b0;
                                if (r_app && idx == SD_CMD41) begin
                                    n_rsp[0] = 32'hc0ff_8000;
                                end else if (xfer) begin
                                    if (bad) begin
                                        flags = IRQ_DTO;
                                    end else if (!xfer_rd && r_locked) begin
                                        flags = IRQ_DCRC;
                                    end else begin
                                        n_ofs  = OFS_W'({arg[22:0], 9'd0});
                                        n_rem  = OFS_W'(total);
                                        n_isrd = xfer_rd;
                                        flags  = xfer_rd ? IRQ_BRR : IRQ_BWR;
                                    end
                                end else begin
                                    case (idx)
                                        SD_CMD0: n_sel = 1'b0;
                                        SD_CMD2: begin
                                            n_rsp[0] = 32'h0353_4453;
                                            n_rsp[1] = 32'h4430_3447;
                                            n_rsp[2] = 32'h8012_3456;
                                            n_rsp[3] = 32'h7801_0001;
                                        end
                                        SD_CMD3: n_rsp[0] = RCA_VALUE;
                                        SD_CMD7: n_sel = (arg == RCA_VALUE);
                                        SD_CMD8: n_rsp[0] = arg;
                                        SD_CMD9: begin
                                            n_rsp[0] = 32'h400e_0032;
                                            n_rsp[1] = {21'd0, r_size};
                                        end
                                        SD_CMD12: begin
                                            n_rem = '0;
                                            flags = IRQ_TC;
                                        end
                                        SD_CMD13: n_rsp[0] = r_sel ? 32'h0000_0800
                                                                   : 32'h0000_0600;
                                        SD_CMD16: begin
                                            if (arg == '0 || arg > 32'(MAX_BLOCK_BYTES)) begin
                                                flags = IRQ_CTO;
                                            end else begin
                                                n_blklen = arg[12:0];
                                            end
                                        end
                                        SD_CMD55: begin
                                            n_app    = 1'b1;
                                            n_rsp[0] = 32'h0000_0020;
                                        end
                                        default: flags = IRQ_CTO;
                                    endcase
                                end
                                flags = flags | IRQ_CC;
                            end
                        end
                    end
                end
            end
            CMD_INSERT: begin
                if (i_card_blocks != '0 && {21'd0, i_card_blocks} <= 32'(MAX_CARD_BLOCKS)) begin
                    acc       = 1'b1;
                    n_size    = i_card_blocks;
                    n_present = 1'b1;
                    n_locked  = i_write_protect;
                    n_sel     = 1'b0;
                    flags     = IRQ_CINS;
                end
            end
            CMD_EJECT: begin
                acc       = 1'b1;
                n_size    = '0;
                n_present = 1'b0;
                n_sel     = 1'b0;
                n_rem     = '0;
                flags     = IRQ_CRM;
            end
            default: acc = 1'b0;
        endcase

        n_irqstat = n_irqstat | (flags & n_irqstaten);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen <= 1'b0;
            r_dsaddr <= '0; r_blkattr <= '0; r_cmdarg <= '0; r_xfertyp <= '0;
            r_proctl <= '0; r_sysctl <= '0; r_irqstat <= '0; r_irqstaten <= '0;
            r_irqsigen <= '0; r_adsaddr <= '0; r_vendor <= '0; r_mmcboot <= '0;
            r_rsp <= '{default: '0};
            r_size <= '0; r_present <= 1'b0; r_locked <= 1'b0; r_sel <= 1'b0;
            r_app <= 1'b0; r_isrd <= 1'b0; r_blklen <= 13'd512;
            r_ofs <= '0; r_rem <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cen <= i_cfg_wdata;
            end
            if (i_step) begin
                r_dsaddr <= n_dsaddr; r_blkattr <= n_blkattr; r_cmdarg <= n_cmdarg;
                r_xfertyp <= n_xfertyp; r_proctl <= n_proctl; r_sysctl <= n_sysctl;
                r_irqstat <= n_irqstat; r_irqstaten <= n_irqstaten;
                r_irqsigen <= n_irqsigen; r_adsaddr <= n_adsaddr;
                r_vendor <= n_vendor; r_mmcboot <= n_mmcboot; r_rsp <= n_rsp;
                r_size <= n_size; r_present <= n_present; r_locked <= n_locked;
                r_sel <= n_sel; r_app <= n_app; r_isrd <= n_isrd;
                r_blklen <= n_blklen; r_ofs <= n_ofs; r_rem <= n_rem;
            end
        end
    end

    assign o_res.acc     = acc;
    assign o_res.port_rd = port_rd;
    assign o_res.rd      = rd;
    assign o_res.mask    = mask;
    assign o_res.irq     = r_cen && ((n_irqstat & n_irqsigen) != '0);

    assign o_mem_we    = i_step && mem_we && (mask != '0);
    assign o_mem_be    = mask;
    assign o_mem_waddr = r_ofs[AW+1:2];
    assign o_mem_wdata = i_write_data;
    assign o_mem_re    = i_step && port_rd;
    assign o_mem_raddr = r_ofs[AW+1:2];

endmodule

// File: rtl/sd_host_register_model.sv
// Channel  | handshake            | beat
// input    | i_valid / o_ready    | i_command, i_bus_address, i_access_size, i_write_data,
//          |                      | i_card_blocks, i_write_protect
// output   | o_valid / i_ready    | o_accepted, o_read_data, o_irq_line
// config   | i_cfg_we             | i_cfg_wdata (clock enable)
//
// One beat in per cycle while o_ready is high; each result passes through the result
// stage and then the output register. Register and card state update at the accept
// edge; the card store registers a data port read and answers it in the result stage.
// After reset the card store is swept clear with o_ready low.
// A stall on the output side fills the result stage and output register, then holds o_ready low.
module sd_host_register_model import sdh_pkg::*; #(
    parameter int CARD_BYTES      = SDH_CARD_BYTES,
    parameter int MAX_BLOCK_BYTES = SDH_MAX_BLOCK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_bus_address,
    input  logic [7:0]  i_access_size,
    input  logic [31:0] i_write_data,
    input  logic [10:0] i_card_blocks,
    input  logic        i_write_protect,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_accepted,
    output logic [31:0] o_read_data,
    output logic        o_irq_line
);

    localparam int AW = $clog2(CARD_BYTES / 4);

    t_step_res     res, r_p_res;
    logic          r_p_valid, r_o_valid, r_o_acc, r_o_irq;
    logic [31:0]   r_o_rd, p_rd, mem_rdata;
    logic          step, p_adv, busy;
    logic          mem_we, mem_re;
    logic [3:0]    mem_be;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata;

    assign p_adv   = !r_o_valid || i_ready;
    assign o_ready = !busy && (!r_p_valid || p_adv);
    assign step    = i_valid && o_ready;

    sdh_regs #(
        .CARD_BYTES      (CARD_BYTES),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_step          (step),
        .i_command       (i_command),
        .i_bus_address   (i_bus_address),
        .i_access_size   (i_access_size),
        .i_write_data    (i_write_data),
        .i_card_blocks   (i_card_blocks),
        .i_write_protect (i_write_protect),
        .o_res           (res),
        .o_mem_we        (mem_we),
        .o_mem_be        (mem_be),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr)
    );

    sdh_store #(
        .CARD_BYTES (CARD_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_be    (mem_be),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (busy)
    );

    // Merge store bytes for a data port read
    always_comb begin
        p_rd = r_p_res.rd;
        if (r_p_res.port_rd) begin
            for (int b = 0; b < 4; b++) begin
                p_rd[8*b +: 8] = r_p_res.mask[b] ? mem_rdata[8*b +: 8] : 8'd0;
            end
        end
    end

    // Result stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (step) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (p_adv) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_p_res <= res;
        end
        if (p_adv && r_p_valid) begin
            r_o_acc <= r_p_res.acc;
            r_o_rd  <= r_p_res.acc ? p_rd : 32'd0;
            r_o_irq <= r_p_res.irq;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_accepted  = r_o_acc;
    assign o_read_data = r_o_rd;
    assign o_irq_line  = r_o_irq;

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_read_data == 32'd0)
        else $error("refused access returned nonzero data");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_ready && !mem_we)
        else $error("store access during clear pass");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_p_valid)
        else $error("accepted beat lost before result stage");

    a_port_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> r_p_res.port_rd)
        else $error("store read without a matching data port result");

endmodule

// File: tb/sd_host_register_model_tb.sv
module sd_host_register_model_tb;
    import sdh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT = 800000;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [7:0]  size;
        logic [31:0] wdata;
        logic [10:0] blocks;
        logic        wp;
    } t_sd_beat;

    typedef struct {
        logic        acc;
        logic [31:0] rd;
        logic        irq;
    } t_sd_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_READ;
    logic [31:0] i_bus_address = '0;
    logic [7:0]  i_access_size = '0;
    logic [31:0] i_write_data = '0;
    logic [10:0] i_card_blocks = '0;
    logic        i_write_protect = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_accepted;
    logic [31:0] o_read_data;
    logic        o_irq_line;

    sd_host_register_model uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_bus_address  (i_bus_address),
        .i_access_size  (i_access_size),
        .i_write_data   (i_write_data),
        .i_card_blocks  (i_card_blocks),
        .i_write_protect(i_write_protect),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_accepted     (o_accepted),
        .o_read_data    (o_read_data),
        .o_irq_line     (o_irq_line)
    );

    always #5 i_clk = ~i_clk;

    // Host controller shadow state
    logic [31:0] host_regs [64];
    logic [7:0]  card_mem [int];
    logic [10:0] card_size_q;
    logic        card_in, card_locked, card_sel, acmd_pending;
    logic [12:0] blk_len;
    logic [19:0] xfer_off;
    logic [27:0] xfer_left;
    logic        xfer_rd;
    logic        clk_en;

    t_sd_beat    pending_beats [$];
    t_sd_result  expected_results [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycles = 0;
    logic        beat_taken = 1'b0;

    function automatic void irq_raise(logic [31:0] flags);
        host_regs[W_IRQSTAT] |= flags & host_regs[W_IRQSTATEN];
    endfunction

    function automatic void reset_host_logic();
        xfer_off = '0;
        xfer_left = '0;
        blk_len = 13'd512;
        acmd_pending = 1'b0;
        card_sel = 1'b0;
        xfer_rd = 1'b0;
        foreach (host_regs[i]) host_regs[i] = '0;
        host_regs[W_HTCAPBLT] = CAP_VALUE;
        host_regs[W_WML] = WML_VALUE;
        host_regs[W_HOSTVER] = VER_VALUE;
    endfunction

    function automatic logic [31:0] prs_word();
        logic [31:0] v;
        v = 32'h8;
        if (card_in) v |= 32'hff81_0000;
        if (xfer_left != 0) v |= xfer_rd ? 32'h0000_0a04 : 32'h0000_0504;
        return v;
    endfunction

    function automatic void end_transfer();
        xfer_left = '0;
        irq_raise(IRQ_TC);
    endfunction

    function automatic void open_xfer(logic is_rd, logic multi);
        logic [63:0] bsize, bcount, offs, total, cap;
        bsize = 64'(host_regs[W_BLKATTR][12:0]);
        bcount = 1;
        offs = 64'(host_regs[W_CMDARG]) * 512;
        cap = 64'(card_size_q) * 512;
        if (bsize == 0) bsize = 64'(blk_len);
        if (multi) begin
            bcount = 64'(host_regs[W_BLKATTR][31:16]);
            if (bcount == 0) bcount = 1;
        end
        total = bsize * bcount;
        if (!card_sel || bsize == 0 || bsize > SDH_MAX_BLOCK_BYTES || offs > cap ||
            total > cap - offs) begin
            irq_raise(IRQ_DTO);
        end else if (!is_rd && card_locked) begin
            irq_raise(IRQ_DCRC);
        end else begin
            xfer_off = offs[19:0];
            xfer_left = total[27:0];
            xfer_rd = is_rd;
            irq_raise(is_rd ? IRQ_BRR : IRQ_BWR);
        end
    endfunction

    function automatic void run_sd_command();
        logic [5:0]  idx;
        logic [31:0] arg;
        idx = host_regs[W_XFERTYP][29:24];
        arg = host_regs[W_CMDARG];
        host_regs[W_RSP0] = '0;
        host_regs[W_RSP1] = '0;
        host_regs[W_RSP2] = '0;
        host_regs[W_RSP3] = '0;
        if (idx != SD_CMD0 && !card_in) begin
            irq_raise(IRQ_CTO);
            return;
        end
        if (acmd_pending && idx == SD_CMD41) begin
            host_regs[W_RSP0] = 32'hc0ff_8000;
            acmd_pending = 1'b0;
        end else begin
            acmd_pending = 1'b0;
            case (idx)
                SD_CMD0: card_sel = 1'b0;
                SD_CMD2: begin
                    host_regs[W_RSP0] = 32'h0353_4453;
                    host_regs[W_RSP1] = 32'h4430_3447;
                    host_regs[W_RSP2] = 32'h8012_3456;
                    host_regs[W_RSP3] = 32'h7801_0001;
                end
                SD_CMD3: host_regs[W_RSP0] = RCA_VALUE;
                SD_CMD7: card_sel = (arg == RCA_VALUE);
                SD_CMD8: host_regs[W_RSP0] = arg;
                SD_CMD9: begin
                    host_regs[W_RSP0] = 32'h400e_0032;
                    host_regs[W_RSP1] = 32'(card_size_q);
                end
                SD_CMD12: end_transfer();
                SD_CMD13: host_regs[W_RSP0] = card_sel ? 32'h800 : 32'h600;
                SD_CMD16: begin
                    if (arg == 0 || arg > SDH_MAX_BLOCK_BYTES) irq_raise(IRQ_CTO);
                    else blk_len = arg[12:0];
                end
                SD_CMD17: open_xfer(1'b1, 1'b0);
                SD_CMD18: open_xfer(1'b1, 1'b1);
                SD_CMD24: open_xfer(1'b0, 1'b0);
                SD_CMD25: open_xfer(1'b0, 1'b1);
                SD_CMD55: begin
                    acmd_pending = 1'b1;
                    host_regs[W_RSP0] = 32'h20;
                end
                default: irq_raise(IRQ_CTO);
            endcase
        end
        irq_raise(IRQ_CC);
    endfunction

    // Move up to one word through the data port
    function automatic logic [31:0] data_port_move(logic [31:0] wd);
        logic [31:0] v, a;
        int n;
        v = '0;
        n = (xfer_left >= 4) ? 4 : int'(xfer_left);
        for (int i = 0; i < n; i++) begin
            a = 32'(xfer_off) + 32'(i);
            if (a < SDH_CARD_BYTES) begin
                if (xfer_rd) begin
                    if (card_mem.exists(a)) v |= 32'(card_mem[a]) << (8 * i);
                end else begin
                    card_mem[a] = wd[8*i +: 8];
                end
            end
        end
        xfer_off += 20'(n);
        xfer_left -= 28'(n);
        if (xfer_left == 0) end_transfer();
        return v;
    endfunction

    function automatic logic is_readable(logic [5:0] w);
        return w <= W_WML || w == W_ADMAES || w == W_ADSADDR || w == W_VENDOR ||
               w == W_MMCBOOT || w == W_HOSTVER;
    endfunction

    function automatic logic is_writable(logic [5:0] w);
        return w <= W_XFERTYP || w == W_DATPORT || (w >= W_PROCTL && w <= W_IRQSIGEN) ||
               w == W_FEVT || w == W_ADSADDR || w == W_VENDOR || w == W_MMCBOOT;
    endfunction

    function automatic t_sd_result predict_host_step(t_sd_beat b);
        t_sd_result r;
        logic [31:0] off;
        logic [5:0]  w;
        logic        hit;
        r = '{acc: 1'b0, rd: '0, irq: 1'b0};
        off = b.addr - HOST_BASE;
        w = off[7:2];
        hit = clk_en && b.size == 8'd4 && b.addr >= HOST_BASE && off <= 32'hfc &&
              off[1:0] == 2'b00;
        case (b.cmd)
            CMD_READ: if (hit) begin
                if (w == W_DATPORT) begin
                    if (xfer_rd && xfer_left != 0) begin
                        r.rd = data_port_move('0);
                        r.acc = 1'b1;
                    end
                end else if (is_readable(w)) begin
                    r.rd = (w == W_PRSSTAT) ? prs_word() : host_regs[w];
                    r.acc = 1'b1;
                end
            end
            CMD_WRITE: if (hit && is_writable(w)) begin
                r.acc = 1'b1;
                if (w == W_DATPORT) begin
                    r.acc = !xfer_rd && xfer_left != 0;
                    if (r.acc) void'(data_port_move(b.wdata));
                end else if (w == W_IRQSTAT) begin
                    host_regs[W_IRQSTAT] &= ~b.wdata;
                end else if (w == W_FEVT) begin
                    irq_raise(b.wdata);
                end else if (w == W_SYSCTL && (b.wdata & SRST_MASK) != 0) begin
                    reset_host_logic();
                    host_regs[W_SYSCTL] = b.wdata & SYSCTL_KEEP;
                end else begin
                    host_regs[w] = b.wdata;
                    if (w == W_XFERTYP) run_sd_command();
                end
            end
            CMD_INSERT: if (b.blocks != 0 && b.blocks <= SDH_CARD_BYTES / 512) begin
                card_size_q = b.blocks;
                card_in = 1'b1;
                card_locked = b.wp;
                card_sel = 1'b0;
                irq_raise(IRQ_CINS);
                r.acc = 1'b1;
            end
            default: begin
                card_size_q = '0;
                card_in = 1'b0;
                card_sel = 1'b0;
                xfer_left = '0;
                irq_raise(IRQ_CRM);
                r.acc = 1'b1;
            end
        endcase
        r.irq = clk_en && (host_regs[W_IRQSTAT] & host_regs[W_IRQSIGEN]) != 0;
        return r;
    endfunction

    // Take input beats and predict at the accept edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(predict_host_step(pending_beats.pop_front()));
            beat_taken <= 1'b1;
        end else begin
            beat_taken <= 1'b0;
        end
    end

    // Drive beats in bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_valid || beat_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                i_command <= pending_beats[0].cmd;
                i_bus_address <= pending_beats[0].addr;
                i_access_size <= pending_beats[0].size;
                i_write_data <= pending_beats[0].wdata;
                i_card_blocks <= pending_beats[0].blocks;
                i_write_protect <= pending_beats[0].wp;
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the result side; one long hold-off fills the pipe
    int hold_left = 0;
    logic long_hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!long_hold_done && results_seen >= 120) begin
            long_hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if ((results_seen / 64) % 3 == 2) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_sd_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat acc=%0b rd=%h irq=%0b",
                             o_accepted, o_read_data, o_irq_line);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_accepted !== exp_r.acc || o_read_data !== exp_r.rd ||
                    o_irq_line !== exp_r.irq) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp acc=%0b rd=%h irq=%0b got %0b %h %0b",
                                 results_seen, exp_r.acc, exp_r.rd, exp_r.irq,
                                 o_accepted, o_read_data, o_irq_line);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus helpers
    function automatic void add_beat(logic [1:0] c, logic [31:0] a, logic [7:0] s,
                                     logic [31:0] d, logic [10:0] bl, logic p);
        pending_beats.push_back('{cmd: c, addr: a, size: s, wdata: d, blocks: bl, wp: p});
    endfunction

    function automatic void reg_rd(logic [5:0] w);
        add_beat(CMD_READ, HOST_BASE + {24'd0, w, 2'b00}, 8'd4, $urandom, 11'($urandom),
                 1'($urandom));
    endfunction

    function automatic void reg_wr(logic [5:0] w, logic [31:0] d);
        add_beat(CMD_WRITE, HOST_BASE + {24'd0, w, 2'b00}, 8'd4, d, 11'($urandom),
                 1'($urandom));
    endfunction

    function automatic void sd_cmd(logic [5:0] idx, logic [31:0] arg);
        reg_wr(W_CMDARG, arg);
        reg_wr(W_XFERTYP, {2'b00, idx, 24'(($urandom & 32'hff)) });
    endfunction

    function automatic void card_insert(logic [10:0] bl, logic p);
        add_beat(CMD_INSERT, $urandom, 8'($urandom), $urandom, bl, p);
    endfunction

    function automatic void card_eject();
        add_beat(CMD_EJECT, $urandom, 8'($urandom), $urandom, 11'($urandom), 1'($urandom));
    endfunction

    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_results.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_clock_gate(logic en);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= en;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        clk_en = en;
    endtask

    // Random block transfer setup and data port accesses; the setup may be refused
    function automatic void random_transfer();
        logic [12:0] bsize;
        logic [15:0] bcount;
        logic        is_rd, multi;
        int          words;
        bsize = ($urandom_range(0, 9) == 0) ? 13'd512 : 13'($urandom_range(1, 13));
        bcount = 16'($urandom_range(0, 3));
        is_rd = 1'($urandom_range(0, 1));
        multi = 1'($urandom_range(0, 1));
        reg_wr(W_BLKATTR, {bcount, 3'b000, bsize});
        sd_cmd(is_rd ? (multi ? SD_CMD18 : SD_CMD17) : (multi ? SD_CMD25 : SD_CMD24),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 4));
        words = (int'(bsize) * (multi ? ((bcount == 0) ? 1 : int'(bcount)) : 1) + 3) / 4;
        if (bsize == 13'd512) words = $urandom_range(1, 8);
        for (int i = 0; i < words + $urandom_range(0, 1); i++) begin
            if ($urandom_range(0, 30) == 0) sd_cmd(SD_CMD12, $urandom);
            if (is_rd) reg_rd(W_DATPORT);
            else reg_wr(W_DATPORT, $urandom);
        end
    endfunction

    function automatic void card_bring_up();
        card_insert(11'($urandom_range(1, 1024)), $urandom_range(0, 5) == 0);
        sd_cmd(SD_CMD0, $urandom);
        sd_cmd(SD_CMD8, $urandom);
        sd_cmd(SD_CMD55, $urandom);
        sd_cmd(SD_CMD41, $urandom);
        sd_cmd(SD_CMD2, $urandom);
        sd_cmd(SD_CMD3, $urandom);
        sd_cmd(SD_CMD9, $urandom);
        sd_cmd(SD_CMD7, ($urandom_range(0, 7) == 0) ? $urandom : RCA_VALUE);
        sd_cmd(SD_CMD13, $urandom);
        if ($urandom_range(0, 1)) sd_cmd(SD_CMD16, $urandom_range(0, 5000));
    endfunction

    function automatic void random_noise();
        logic [5:0] w;
        w = 6'($urandom);
        case ($urandom_range(0, 7))
            0: add_beat(2'($urandom), $urandom, 8'($urandom), $urandom, 11'($urandom),
                        1'($urandom));
            1: add_beat(2'($urandom), HOST_BASE + ($urandom & 32'h1ff), ($urandom_range(0, 1) ?
                        8'd4 : 8'($urandom)), $urandom, 11'($urandom), 1'($urandom));
            2: reg_rd(w);
            3: reg_wr(w == W_XFERTYP ? W_PROCTL : w, $urandom);
            4: reg_wr(W_IRQSTAT, $urandom);
            5: reg_wr(W_FEVT, $urandom);
            6: sd_cmd(6'($urandom), $urandom);
            default: reg_wr(W_SYSCTL, $urandom & ($urandom_range(0, 3) == 0 ?
                            32'hffff_ffff : 32'hf8ff_ffff));
        endcase
    endfunction

    task automatic random_phase(int count);
        int start_n;
        start_n = pending_beats.size();
        while (pending_beats.size() - start_n < count) begin
            case ($urandom_range(0, 19))
                0: card_bring_up();
                1: card_eject();
                2: begin
                    reg_wr(W_IRQSTATEN, ($urandom_range(0, 3) == 0) ? $urandom : 32'hffff_ffff);
                    reg_wr(W_IRQSIGEN, $urandom);
                end
                3, 4, 5, 6: random_noise();
                7: reg_rd(W_PRSSTAT);
                default: random_transfer();
            endcase
        end
    endtask

    initial begin
        reset_host_logic();
        card_mem.delete();
        card_size_q = '0;
        card_in = 1'b0;
        card_locked = 1'b0;
        clk_en = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_clock_gate(1'b0);

        // Gated clock: accesses refused, card events still taken
        reg_rd(W_HOSTVER);
        reg_wr(W_IRQSTATEN, 32'hffff_ffff);
        card_insert(11'd0, 1'b0);
        card_insert(11'd1025, 1'b0);
        card_insert(11'd2047, 1'b1);
        card_insert(11'd1024, 1'b1);
        card_eject();
        wait_idle();
        set_clock_gate(1'b1);

        // Directed corners
        add_beat(CMD_READ, HOST_BASE, 8'd2, '0, '0, 1'b0);
        add_beat(CMD_READ, HOST_BASE + 32'd2, 8'd4, '0, '0, 1'b0);
        add_beat(CMD_READ, HOST_BASE - 32'd4, 8'd4, '0, '0, 1'b0);
        add_beat(CMD_READ, HOST_BASE + 32'h100, 8'd4, '0, '0, 1'b0);
        add_beat(CMD_WRITE, 32'hffff_fffc, 8'hff, 32'hffff_ffff, 11'h7ff, 1'b1);
        reg_rd(6'd18);
        reg_wr(W_PRSSTAT, 32'hffff_ffff);
        reg_rd(W_PRSSTAT);
        reg_rd(W_HTCAPBLT);
        reg_wr(W_IRQSTATEN, 32'hffff_ffff);
        reg_wr(W_IRQSIGEN, 32'hffff_ffff);
        sd_cmd(SD_CMD2, '0);
        card_insert(11'd1, 1'b0);
        sd_cmd(6'd5, '0);
        reg_rd(W_DATPORT);
        reg_wr(W_DATPORT, 32'h1234_5678);
        sd_cmd(SD_CMD16, '0);
        reg_wr(W_FEVT, 32'hffff_ffff);
        reg_wr(W_IRQSTAT, 32'hffff_ffff);
        reg_wr(W_SYSCTL, 32'hffff_ffff);
        reg_rd(W_SYSCTL);
        wait_idle();

        random_phase(200);
        wait_idle();
        set_clock_gate(1'b0);
        random_phase(15);
        wait_idle();
        set_clock_gate(1'b1);
        random_phase(200);
        wait_idle();
        repeat (20) @(posedge i_clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sd_host_register_model.f
rtl/sdh_pkg.sv
rtl/sdh_store.sv
rtl/sdh_regs.sv
rtl/sd_host_register_model.sv
tb/sd_host_register_model_tb.sv
